FILE: design/quoted_command_line_tokenizer_unit_defines.svh
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define QUOTED_COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH

// label: property checked at every edge outside reset
`define QCLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// label: antecedent implies consequent in the next cycle, outside reset
`define QCLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/qclt_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Constants, result codes and result records shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qclt_pkg;

  localparam int MAX_ARGS  = 10;
  localparam int LINE_MAX  = 64;
  localparam int PKT_SLOTS = 3;
  localparam int PKT_DEPTH = 2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BELL   = 8'h07;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BLANK    = 2'd1;
  localparam logic [1:0] ST_UNBAL    = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [3:0] token_index;
    logic [6:0] token_length;
    logic       strip_quotes;
    logic [1:0] status;
    logic [3:0] arg_count;
    logic       last;
  } res_t;

  // results caused by one input item, compacted from slot 0 up
  typedef struct packed {
    res_t [PKT_SLOTS-1:0] slot;
    logic [1:0]           n;
  } pkt_t;

endpackage

FILE: design/qclt_core.sv
// ----------------------------------------------------------------------------
// Tokenizer core
// Line state registers and the per-character step that forms the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qclt_core
  import qclt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       end_of_line,
  output pkt_t       pkt
);

  logic       quote_open, quote_open_next;
  logic [7:0] open_quote_char, open_quote_char_next;
  logic       in_token, in_token_next;
  logic [3:0] token_total, token_total_next;
  logic [6:0] current_length, current_length_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] last_byte, last_byte_next;
  logic       overflow_seen, overflow_seen_next;

  logic       ws, is_quote, tok, start, full;
  logic       qo1, in1, ovf1;
  logic [7:0] oqc1, first1, last1;
  logic [3:0] tt1;
  logic [6:0] len_base, len1;
  logic       has_byte, has_end, has_stat;
  res_t       byte_r, end_r, stat_r;
  logic [1:0] n;
  logic [1:0] st;

  function automatic logic strip_of(input logic [7:0] f, input logic [7:0] l);
    strip_of = (f == CH_SQUOTE || f == CH_DQUOTE) && (l == f);
  endfunction

  always_comb begin
    ws       = (char_in == CH_SPACE) || (char_in == CH_TAB) ||
               (char_in == CH_LF) || (char_in == CH_CR);
    is_quote = (char_in == CH_SQUOTE) || (char_in == CH_DQUOTE);

    qo1  = quote_open;
    oqc1 = open_quote_char;
    if (is_quote) begin
      if (!quote_open) begin
        qo1  = 1'b1;
        oqc1 = char_in;
      end else if (char_in == open_quote_char) begin
        qo1  = 1'b0;
        oqc1 = 8'h00;
      end
    end
    tok = is_quote || !ws || quote_open;

    start    = tok && !in_token;
    full     = token_total >= 4'(MAX_ARGS);
    tt1      = (start && !full) ? token_total + 4'd1 : token_total;
    ovf1     = overflow_seen || (start && full);
    first1   = start ? char_in : first_byte;
    last1    = tok ? char_in : last_byte;
    len_base = start ? 7'd0 : current_length;
    len1     = tok ? ((len_base < 7'(LINE_MAX)) ? len_base + 7'd1 : len_base) : 7'd0;
    in1      = tok;

    byte_r             = '0;
    byte_r.kind        = KIND_BYTE;
    byte_r.char_out    = (ws || char_in == CH_BELL) ? CH_SPACE : char_in;
    byte_r.token_index = tt1 - 4'd1;
    has_byte           = tok && !ovf1;

    end_r      = '0;
    end_r.kind = KIND_END;
    if (tok) begin
      has_end            = end_of_line && !ovf1;
      end_r.token_index  = tt1 - 4'd1;
      end_r.token_length = len1;
      end_r.strip_quotes = strip_of(first1, last1);
    end else begin
      has_end            = in_token && !overflow_seen;
      end_r.token_index  = token_total - 4'd1;
      end_r.token_length = current_length;
      end_r.strip_quotes = strip_of(first_byte, last_byte);
    end

    priority if (qo1) st = ST_UNBAL;
    else if (ovf1) st = ST_TOO_MANY;
    else if (tt1 == 4'd0) st = ST_BLANK;
    else st = ST_OK;
    stat_r           = '0;
    stat_r.kind      = KIND_STATUS;
    stat_r.status    = st;
    stat_r.arg_count = tt1;
    has_stat         = end_of_line;

    pkt = '0;
    n   = 2'd0;
    if (has_byte) begin
      pkt.slot[n] = byte_r;
      n = n + 2'd1;
    end
    if (has_end) begin
      pkt.slot[n] = end_r;
      n = n + 2'd1;
    end
    if (has_stat) begin
      pkt.slot[n] = stat_r;
      n = n + 2'd1;
    end
    if (n != 2'd0) begin
      pkt.slot[n - 2'd1].last = 1'b1;
    end
    pkt.n = n;

    if (end_of_line) begin
      quote_open_next      = 1'b0;
      open_quote_char_next = 8'h00;
      in_token_next        = 1'b0;
      token_total_next     = 4'd0;
      current_length_next  = 7'd0;
      first_byte_next      = 8'h00;
      last_byte_next       = 8'h00;
      overflow_seen_next   = 1'b0;
    end else begin
      quote_open_next      = qo1;
      open_quote_char_next = oqc1;
      in_token_next        = in1;
      token_total_next     = tt1;
      current_length_next  = len1;
      first_byte_next      = first1;
      last_byte_next       = last1;
      overflow_seen_next   = ovf1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_open      <= 1'b0;
      open_quote_char <= 8'h00;
      in_token        <= 1'b0;
      token_total     <= 4'd0;
      current_length  <= 7'd0;
      first_byte      <= 8'h00;
      last_byte       <= 8'h00;
      overflow_seen   <= 1'b0;
    end else if (accept) begin
      quote_open      <= quote_open_next;
      open_quote_char <= open_quote_char_next;
      in_token        <= in_token_next;
      token_total     <= token_total_next;
      current_length  <= current_length_next;
      first_byte      <= first_byte_next;
      last_byte       <= last_byte_next;
      overflow_seen   <= overflow_seen_next;
    end
  end

endmodule

FILE: design/quoted_command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Quoted command-line tokenizer
// Splits a command line, one character per item, into token bytes, token
// ends and an end-of-line status.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per item in tdata[7:0]; tlast marks the last
//   character of a line. m_axis carries results: tuser is the kind (byte, token
//   end, line status), tdata the payload fields, tlast the final result of the
//   input item that caused it.
//   The results of an item are registered into the result buffer when it is
//   accepted, and are offered from there in order.
//   Throughput: one item per cycle while m_axis_tready is high and each item
//   gives at most one result. An item that gives two or three results holds
//   the single output port while they are sent one by one; a two-entry buffer
//   of per-item result groups sits between the step logic and the output, and
//   s_axis_tready is low only while both entries are in use.
//   Reset clears the line state and drops buffered results.
//   When the receiver stalls, results wait in the buffer and input is taken
//   until it fills; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quoted_command_line_tokenizer_unit_defines.svh"

module quoted_command_line_tokenizer_unit
  import qclt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] char_out, [11:8] token_index,
                                      // [18:12] token_length, [19] strip_quotes,
                                      // [21:20] status, [25:22] arg_count
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  pkt_t       pkt;
  pkt_t       buf_q [PKT_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;
  logic [1:0] slot;
  logic       accept, push, pop, head_done;
  pkt_t       head;
  res_t       res;

  assign s_axis_tready = (count != 2'(PKT_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  qclt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_in     (s_axis_tdata),
    .end_of_line (s_axis_tlast),
    .pkt         (pkt)
  );

  assign push      = accept && (pkt.n != 2'd0);
  assign head      = buf_q[rd_ptr];
  assign res       = head.slot[slot];
  assign pop       = m_axis_tvalid && m_axis_tready;
  assign head_done = pop && (slot == head.n - 2'd1);

  always_comb begin
    count_next = count;
    if (push && !head_done) begin
      count_next = count + 2'd1;
    end else if (!push && head_done) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      slot   <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (head_done) begin
        rd_ptr <= !rd_ptr;
        slot   <= 2'd0;
      end else if (pop) begin
        slot <= slot + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= pkt;
    end
  end

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tuser  = res.kind;
  assign m_axis_tlast  = res.last;
  assign m_axis_tdata  = {6'd0, res.arg_count, res.status, res.strip_quotes,
                          res.token_length, res.token_index, res.char_out};

  `QCLT_ASSERT(a_count_bound, count <= 2'(PKT_DEPTH), "result buffer overfilled")
  `QCLT_ASSERT(a_slot_in_range, (count != 2'd0) |-> (slot < head.n), "slot past group end")
  `QCLT_ASSERT(a_status_is_last, (m_axis_tvalid && m_axis_tuser == KIND_STATUS) |-> m_axis_tlast, "status not last")
  `QCLT_ASSERT_NEXT(a_push_shows, count == 2'd0 && push, m_axis_tvalid, "pushed group not offered")

endmodule
